// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define VPA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication failed");

// next-cycle implication
`define VPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle implication failed");

`endif

// ===== sv/vpa_pkg.sv =====
// ----------------------------------------------------------------------------
// vpa_pkg
// Types and constants of the variable partition allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vpa_pkg;

   localparam int FREE_ENTRIES = 16;
   localparam int USED_ENTRIES = 16;
   localparam int ADDR_BITS    = 16;
   localparam int SIZE_BITS    = ADDR_BITS + 1;
   localparam int OWNER_BITS   = 8;
   localparam int RIDX_BITS    = 4;
   localparam int FIDX_BITS    = $clog2(FREE_ENTRIES);
   localparam int UIDX_BITS    = $clog2(USED_ENTRIES);
   localparam int LAP_LEN      = (FREE_ENTRIES > USED_ENTRIES) ? FREE_ENTRIES : USED_ENTRIES;
   localparam int STEP_BITS    = $clog2(LAP_LEN + 1);

   localparam logic [1:0] MODE_ADD     = 2'd0;
   localparam logic [1:0] MODE_ALLOC   = 2'd1;
   localparam logic [1:0] MODE_RELEASE = 2'd2;
   localparam logic [1:0] MODE_IGNORED = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOFIT   = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_NOOWNER = 2'd3;

   localparam logic [1:0] POL_FIRST = 2'd0;
   localparam logic [1:0] POL_NEXT  = 2'd1;
   localparam logic [1:0] POL_BEST  = 2'd2;
   localparam logic [1:0] POL_WORST = 2'd3;

   typedef struct packed {
      logic [1:0]            mode;
      logic [OWNER_BITS-1:0] owner;
      logic [15:0]           size;
      logic [15:0]           base;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [15:0]          address;
      logic [RIDX_BITS-1:0] region_index;
   } rsp_type;

   typedef struct packed {
      logic                 valid;
      logic [ADDR_BITS-1:0] base;
      logic [SIZE_BITS-1:0] size;
   } free_entry_type;

   typedef struct packed {
      logic                  valid;
      logic [OWNER_BITS-1:0] owner;
      logic [ADDR_BITS-1:0]  base;
      logic [SIZE_BITS-1:0]  size;
   } used_entry_type;

   typedef struct packed {
      logic           free_shift;
      free_entry_type free_wb;
      logic           used_shift;
      used_entry_type used_wb;
   } ring_ctl_type;

endpackage

// ===== sv/vpa_free_cell.sv =====
// ----------------------------------------------------------------------------
// vpa_free_cell
// One free-region entry of the rotating free table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vpa_free_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    shift,
   input  vpa_pkg::free_entry_type d,
   output vpa_pkg::free_entry_type q
);

   logic                          valid_ff;
   logic [vpa_pkg::ADDR_BITS-1:0] base_ff;
   logic [vpa_pkg::SIZE_BITS-1:0] size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= d.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         base_ff <= d.base;
         size_ff <= d.size;
      end
   end

   assign q = '{valid: valid_ff, base: base_ff, size: size_ff};

endmodule

// ===== sv/vpa_used_cell.sv =====
// ----------------------------------------------------------------------------
// vpa_used_cell
// One allocation entry of the rotating used table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vpa_used_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    shift,
   input  vpa_pkg::used_entry_type d,
   output vpa_pkg::used_entry_type q
);

   logic                           valid_ff;
   logic [vpa_pkg::OWNER_BITS-1:0] owner_ff;
   logic [vpa_pkg::ADDR_BITS-1:0]  base_ff;
   logic [vpa_pkg::SIZE_BITS-1:0]  size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= d.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         owner_ff <= d.owner;
         base_ff  <= d.base;
         size_ff  <= d.size;
      end
   end

   assign q = '{valid: valid_ff, owner: owner_ff, base: base_ff, size: size_ff};

endmodule

// ===== sv/vpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// vpa_ctrl
// Sequencer: watches the ring heads lap by lap, edits entries as they pass,
// and owns the request, result and policy registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vpa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  vpa_pkg::req_type        req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output vpa_pkg::rsp_type        rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_data,
   input  vpa_pkg::free_entry_type free_head,
   input  vpa_pkg::used_entry_type used_head,
   output vpa_pkg::ring_ctl_type   ring_ctl
);

   localparam int AB = vpa_pkg::ADDR_BITS;
   localparam int SB = vpa_pkg::SIZE_BITS;
   localparam int FB = vpa_pkg::FIDX_BITS;
   localparam int UB = vpa_pkg::UIDX_BITS;
   localparam int TB = vpa_pkg::STEP_BITS;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_FIND   = 5'b00010,
      S_SCAN   = 5'b00100,
      S_UPDATE = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [TB-1:0]     step_ff, step_in;
   logic [1:0]        policy_ff;
   logic [FB-1:0]     rover_ff;
   logic              rsp_valid_ff;
   vpa_pkg::rsp_type  rsp_data_ff;

   logic [1:0]                     mode_ff;
   logic [vpa_pkg::OWNER_BITS-1:0] owner_ff;
   logic [AB-1:0]                  base_ff;
   logic [SB-1:0]                  size_ff;
   logic [1:0]                     status_ff;
   logic [AB-1:0]                  addr_ff;
   logic [FB-1:0]                  ridx_ff;

   logic          f_hit_ff, lo_hit_ff, u_hit_ff, left_hit_ff, right_hit_ff, e_hit_ff;
   logic [FB-1:0] f_idx_ff, lo_idx_ff, left_idx_ff, right_idx_ff, e_idx_ff;
   logic [AB-1:0] f_base_ff, lo_base_ff, rb_ff;
   logic [SB-1:0] f_size_ff, rs_ff, right_size_ff;
   logic [UB-1:0] u_idx_ff;

   logic          last, fon, uon, fit, better, busy, load_rsp;
   logic [FB-1:0] fk;
   logic [UB-1:0] uk;
   logic [SB-1:0] room, req_size, new_size;
   logic          sel_hit, both;
   logic [FB-1:0] sel_idx;
   logic [AB-1:0] sel_base;
   vpa_pkg::free_entry_type fwb;
   vpa_pkg::used_entry_type uwb;

   assign fk   = step_ff[FB-1:0];
   assign uk   = step_ff[UB-1:0];
   assign fon  = ({1'b0, step_ff} < (TB+1)'(vpa_pkg::FREE_ENTRIES));
   assign uon  = ({1'b0, step_ff} < (TB+1)'(vpa_pkg::USED_ENTRIES));
   assign last = (step_ff == TB'(vpa_pkg::LAP_LEN));
   assign busy = (state_ff == S_FIND) || (state_ff == S_SCAN) || (state_ff == S_UPDATE);
   assign fit  = free_head.valid && (free_head.size >= size_ff);

   always_comb begin
      if (free_head.size != f_size_ff) begin
         better = (policy_ff == vpa_pkg::POL_BEST) ? (free_head.size < f_size_ff)
                                                   : (free_head.size > f_size_ff);
      end else begin
         better = free_head.base < f_base_ff;
      end
   end

   assign room     = SB'(1 << AB) - {1'b0, req_data.base[AB-1:0]};
   assign req_size = {1'b0, req_data.size[AB-1:0]};
   assign new_size = free_head.size - size_ff;
   assign sel_hit  = f_hit_ff || lo_hit_ff;
   assign sel_idx  = f_hit_ff ? f_idx_ff : lo_idx_ff;
   assign sel_base = f_hit_ff ? f_base_ff : lo_base_ff;
   assign both     = left_hit_ff && right_hit_ff && (left_idx_ff != right_idx_ff);

   // head write-back
   always_comb begin
      fwb = free_head;
      uwb = used_head;
      if ((state_ff == S_UPDATE) && (status_ff == vpa_pkg::ST_OK)) begin
         case (mode_ff)
            vpa_pkg::MODE_ADD: begin
               if (fon && !free_head.valid && !e_hit_ff && (size_ff != '0)) begin
                  fwb = '{valid: 1'b1, base: base_ff, size: size_ff};
               end
            end
            vpa_pkg::MODE_ALLOC: begin
               if (fon && (fk == f_idx_ff)) begin
                  fwb.base  = free_head.base + size_ff[AB-1:0];
                  fwb.size  = new_size;
                  fwb.valid = (new_size != '0);
               end
               if (uon && (uk == u_idx_ff)) begin
                  uwb = '{valid: 1'b1, owner: owner_ff, base: f_base_ff, size: size_ff};
               end
            end
            vpa_pkg::MODE_RELEASE: begin
               if (fon) begin
                  if (both) begin
                     if (fk == left_idx_ff) begin
                        fwb.size = free_head.size + rs_ff + right_size_ff;
                     end else if (fk == right_idx_ff) begin
                        fwb.valid = 1'b0;
                     end
                  end else if (left_hit_ff) begin
                     if (fk == left_idx_ff) begin
                        fwb.size = free_head.size + rs_ff;
                     end
                  end else if (right_hit_ff) begin
                     if (fk == right_idx_ff) begin
                        fwb.base = rb_ff;
                        fwb.size = free_head.size + rs_ff;
                     end
                  end else if (fk == e_idx_ff) begin
                     fwb = '{valid: 1'b1, base: rb_ff, size: rs_ff};
                  end
               end
               if (uon && (uk == u_idx_ff)) begin
                  uwb.valid = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign ring_ctl = '{free_shift: busy && fon, free_wb: fwb,
                       used_shift: busy && uon, used_wb: uwb};

   assign load_rsp = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      step_in  = busy ? step_ff + TB'(1) : '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_data.mode)
                  vpa_pkg::MODE_ADD:     state_in = S_UPDATE;
                  vpa_pkg::MODE_ALLOC:   state_in = S_SCAN;
                  vpa_pkg::MODE_RELEASE: state_in = S_FIND;
                  default:               state_in = S_FINISH;
               endcase
            end
         end
         S_FIND: begin
            if (last) begin
               state_in = u_hit_ff ? S_SCAN : S_FINISH;
               step_in  = '0;
            end
         end
         S_SCAN: begin
            if (last) begin
               step_in = '0;
               if (mode_ff == vpa_pkg::MODE_ALLOC) begin
                  state_in = ((size_ff != '0) && u_hit_ff && sel_hit) ? S_UPDATE : S_FINISH;
               end else begin
                  state_in = (left_hit_ff || right_hit_ff || e_hit_ff) ? S_UPDATE : S_FINISH;
               end
            end
         end
         S_UPDATE: begin
            if (last) begin
               state_in = S_FINISH;
               step_in  = '0;
            end
         end
         S_FINISH: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         policy_ff    <= vpa_pkg::POL_FIRST;
         rover_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if (csr_valid) begin
            policy_ff <= csr_data;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if ((state_ff == S_SCAN) && last && (mode_ff == vpa_pkg::MODE_ALLOC) &&
             (size_ff != '0) && u_hit_ff && sel_hit && (policy_ff == vpa_pkg::POL_NEXT)) begin
            rover_ff <= (sel_idx == FB'(vpa_pkg::FREE_ENTRIES - 1)) ? '0 : sel_idx + FB'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff <= '{status: status_ff, address: addr_ff,
                          region_index: vpa_pkg::RIDX_BITS'(ridx_ff)};
      end
      unique case (state_ff)
         S_IDLE: begin
            mode_ff      <= req_data.mode;
            owner_ff     <= req_data.owner;
            base_ff      <= req_data.base[AB-1:0];
            size_ff      <= ((req_data.mode == vpa_pkg::MODE_ADD) && (req_size > room)) ?
                            room : req_size;
            status_ff    <= vpa_pkg::ST_OK;
            addr_ff      <= '0;
            ridx_ff      <= '0;
            f_hit_ff     <= 1'b0;
            lo_hit_ff    <= 1'b0;
            u_hit_ff     <= 1'b0;
            left_hit_ff  <= 1'b0;
            right_hit_ff <= 1'b0;
            e_hit_ff     <= 1'b0;
            f_size_ff    <= '0;
            f_base_ff    <= '0;
         end
         S_FIND: begin
            if (uon && used_head.valid && (used_head.owner == owner_ff) && !u_hit_ff) begin
               u_hit_ff <= 1'b1;
               u_idx_ff <= uk;
               rb_ff    <= used_head.base;
               rs_ff    <= used_head.size;
            end
            if (last && !u_hit_ff) begin
               status_ff <= vpa_pkg::ST_NOOWNER;
            end
         end
         S_SCAN: begin
            if (mode_ff == vpa_pkg::MODE_ALLOC) begin
               if (fon && fit) begin
                  case (policy_ff)
                     vpa_pkg::POL_FIRST: begin
                        if (!f_hit_ff) begin
                           f_hit_ff  <= 1'b1;
                           f_idx_ff  <= fk;
                           f_base_ff <= free_head.base;
                        end
                     end
                     vpa_pkg::POL_NEXT: begin
                        if (fk >= rover_ff) begin
                           if (!f_hit_ff) begin
                              f_hit_ff  <= 1'b1;
                              f_idx_ff  <= fk;
                              f_base_ff <= free_head.base;
                           end
                        end else if (!lo_hit_ff) begin
                           lo_hit_ff  <= 1'b1;
                           lo_idx_ff  <= fk;
                           lo_base_ff <= free_head.base;
                        end
                     end
                     default: begin
                        if (!f_hit_ff || better) begin
                           f_hit_ff  <= 1'b1;
                           f_idx_ff  <= fk;
                           f_base_ff <= free_head.base;
                           f_size_ff <= free_head.size;
                        end
                     end
                  endcase
               end
               if (uon && !used_head.valid && !u_hit_ff) begin
                  u_hit_ff <= 1'b1;
                  u_idx_ff <= uk;
               end
               if (last) begin
                  f_idx_ff  <= sel_idx;
                  f_base_ff <= sel_base;
                  if (size_ff == '0) begin
                     status_ff <= vpa_pkg::ST_NOFIT;
                  end else if (!u_hit_ff) begin
                     status_ff <= vpa_pkg::ST_FULL;
                  end else if (!sel_hit) begin
                     status_ff <= vpa_pkg::ST_NOFIT;
                  end else begin
                     addr_ff <= sel_base;
                     ridx_ff <= sel_idx;
                  end
               end
            end else begin
               if (fon && free_head.valid) begin
                  if (!left_hit_ff && (({1'b0, free_head.base} + free_head.size) ==
                                       {1'b0, rb_ff})) begin
                     left_hit_ff <= 1'b1;
                     left_idx_ff <= fk;
                  end
                  if (!right_hit_ff && ({1'b0, free_head.base} == ({1'b0, rb_ff} + rs_ff))) begin
                     right_hit_ff  <= 1'b1;
                     right_idx_ff  <= fk;
                     right_size_ff <= free_head.size;
                  end
               end
               if (fon && !free_head.valid && !e_hit_ff) begin
                  e_hit_ff <= 1'b1;
                  e_idx_ff <= fk;
               end
               if (last) begin
                  if (left_hit_ff) begin
                     addr_ff <= rb_ff;
                     ridx_ff <= left_idx_ff;
                  end else if (right_hit_ff) begin
                     addr_ff <= rb_ff;
                     ridx_ff <= right_idx_ff;
                  end else if (e_hit_ff) begin
                     addr_ff <= rb_ff;
                     ridx_ff <= e_idx_ff;
                  end else begin
                     status_ff <= vpa_pkg::ST_FULL;
                  end
               end
            end
         end
         S_UPDATE: begin
            if ((mode_ff == vpa_pkg::MODE_ADD) && fon && !free_head.valid && !e_hit_ff) begin
               e_hit_ff <= 1'b1;
               e_idx_ff <= fk;
            end
            if ((mode_ff == vpa_pkg::MODE_ADD) && last) begin
               if (size_ff == '0) begin
                  addr_ff <= base_ff;
               end else if (e_hit_ff) begin
                  addr_ff <= base_ff;
                  ridx_ff <= e_idx_ff;
               end else begin
                  status_ff <= vpa_pkg::ST_FULL;
               end
            end
         end
         S_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/variable_partition_allocator_top.sv =====
// ----------------------------------------------------------------------------
// variable_partition_allocator_top
// Free/used region tables with first, next, best and worst fit allocation.
// ----------------------------------------------------------------------------
// Requests enter on req_valid/req_ready with req_data (mode, owner, size,
// base); one result per request leaves on rsp_valid/rsp_ready with rsp_data
// (status, address, region_index). csr_valid/csr_data write the 2-bit fit
// policy; csr_ready is always high, write only while no request is pending.
// Both tables are rings of cells that rotate one entry per cycle past a
// sequencer while a request is being worked on; the sequencer reads and
// edits the head entry as it passes. Add region: one lap. Allocate: two
// laps. Release: three laps (fewer when the owner or a region is not
// found).
// One request is in flight at a time; req_ready is high only when idle.
// The result register lets the next request start while a result waits
// for rsp_ready; a new result waits until the held one is taken.
// Synchronous reset empties both tables (valid bits only), clears the
// rover and sets the policy to first fit. No clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module variable_partition_allocator_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  vpa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output vpa_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_data
);

   localparam int NF = vpa_pkg::FREE_ENTRIES;
   localparam int NU = vpa_pkg::USED_ENTRIES;

   vpa_pkg::free_entry_type free_q [NF];
   vpa_pkg::free_entry_type free_d [NF];
   vpa_pkg::used_entry_type used_q [NU];
   vpa_pkg::used_entry_type used_d [NU];
   vpa_pkg::ring_ctl_type   ring_ctl;

   genvar j;
   generate
      for (j = 0; j < NF; j++) begin : g_free
         if (j == NF - 1) begin : g_tail
            assign free_d[j] = ring_ctl.free_wb;
         end else begin : g_mid
            assign free_d[j] = free_q[j+1];
         end
         vpa_free_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (ring_ctl.free_shift),
            .d     (free_d[j]),
            .q     (free_q[j])
         );
      end
      for (j = 0; j < NU; j++) begin : g_used
         if (j == NU - 1) begin : g_tail
            assign used_d[j] = ring_ctl.used_wb;
         end else begin : g_mid
            assign used_d[j] = used_q[j+1];
         end
         vpa_used_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (ring_ctl.used_shift),
            .d     (used_d[j]),
            .q     (used_q[j])
         );
      end
   endgenerate

   vpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .free_head (free_q[0]),
      .used_head (used_q[0]),
      .ring_ctl  (ring_ctl)
   );

endmodule

// ===== sv/vpa_checker.sv =====
// ----------------------------------------------------------------------------
// vpa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vpa_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input vpa_pkg::rsp_type rsp_data
);

   logic failed;
   logic zero_out;

   assign failed   = rsp_valid && (rsp_data.status != vpa_pkg::ST_OK);
   assign zero_out = (rsp_data.address == '0) && (rsp_data.region_index == '0);

   `VPA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `VPA_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `VPA_ASSERT_IMPLY(a_fail_zero, clock, reset, failed, zero_out)
   `VPA_ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, !rsp_valid)

endmodule

bind variable_partition_allocator_top vpa_checker u_vpa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
